/* rtl/rbt_pkg.sv */
package rbt_pkg;

    // Default build size; fixes the link table depth (2 * leaves - 1)
    localparam int MAX_LEAVES_DEF = 256;

    localparam int WORD_W   = 31;   // random word
    localparam int IDX_W    = 9;    // entry index / link value port width
    localparam int STEPS_W  = 8;    // steps_done port width
    localparam int LEAF_W   = 9;    // leaf_count register

    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_ADVANCE = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSTART  = 2'd1;
    localparam logic [1:0] ST_COMPLETE = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

endpackage

/* rtl/rbt_ram.sv */
module rbt_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 511
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

/* rtl/rbt_mod.sv */
module rbt_mod #(
    parameter int DIV_W = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rbt_pkg::WORD_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]          i_divisor,
    output logic                      o_done,
    output logic [DIV_W-1:0]          o_rem
);

    localparam int CNT_W = $clog2(rbt_pkg::WORD_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [rbt_pkg::WORD_W-1:0]  r_dvd;
    logic [DIV_W-1:0]            r_d;
    logic [DIV_W-1:0]            r_rem;
    logic [DIV_W:0]              shifted;
    logic [DIV_W-1:0]            n_rem;

    // restoring step: one dividend bit per cycle, MSB first
    always_comb begin
        shifted = {r_rem, r_dvd[rbt_pkg::WORD_W-1]};
        if (shifted >= {1'b0, r_d}) begin
            n_rem = DIV_W'(shifted - {1'b0, r_d});
        end else begin
            n_rem = DIV_W'(shifted);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(rbt_pkg::WORD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_d   <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[rbt_pkg::WORD_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* rtl/random_binary_tree_link_builder_core.sv */
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: op; tdata: random_value, entry_index
// m_axis    out  m_axis_tvalid/m_axis_tready   tuser: status; tdata: link, steps, complete
// cfg       in   i_cfg_valid/o_cfg_ready       i_cfg_data: leaf_count
//
// Advance: after the input transfer the bit-serial modulo takes the 31 dividend bits
// one at a time, then remainder capture, one read, data capture, three writes on
// the single-port link RAM and the output load. Read: read, data capture, output
// load. Start: clear entry 0, output load. Flagged items: output load only.
// Reset: sync active low; tree not started, leaf_count = 1. Link RAM not cleared.
// s_axis_tready is high only while idle. A result waiting on m_axis does not
// block the next input transfer; only a second finished result waits for it.
module random_binary_tree_link_builder_core #(
    parameter int MAX_LEAVES = rbt_pkg::MAX_LEAVES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // config
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [rbt_pkg::LEAF_W-1:0] i_cfg_data,     // leaf_count
    // input stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [39:0]                s_axis_tdata,   // [30:0] random_value, [39:31] entry_index
    input  logic [1:0]                 s_axis_tuser,   // [1:0] op
    // output stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [23:0]                m_axis_tdata,   // [8:0] link_value, [16:9] steps_done,
                                                       // [17] complete, [23:18] zero
    output logic [1:0]                 m_axis_tuser    // [1:0] status
);

    localparam int DEPTH   = 2 * MAX_LEAVES - 1;
    localparam int AW      = $clog2(DEPTH);
    localparam int NMAX1   = (MAX_LEAVES < 511) ? MAX_LEAVES : 511;
    localparam int NW      = $clog2(NMAX1);
    localparam int DW      = NW + 2;
    localparam int CW      = ((AW > rbt_pkg::IDX_W) ? AW : rbt_pkg::IDX_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_DIV, S_RD, S_CAP, S_WR1, S_WR2, S_WR3, S_OUT
    } t_state;

    t_state                      r_state, n_state;
    logic [1:0]                  r_op, n_op;
    logic [rbt_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic [NW-1:0]               r_n, n_n;
    logic                        r_started, n_started;
    logic [1:0]                  r_status, n_status;
    logic [AW-1:0]               r_k, n_k;
    logic                        r_b, n_b;
    logic [AW-1:0]               r_old, n_old;
    logic [AW-1:0]               r_link, n_link;
    logic [rbt_pkg::LEAF_W-1:0]  r_leaf;
    logic                        r_m_valid, n_m_valid;
    logic [1:0]                  r_m_status, n_m_status;
    logic [rbt_pkg::IDX_W-1:0]   r_m_link, n_m_link;
    logic [rbt_pkg::STEPS_W-1:0] r_m_steps, n_m_steps;
    logic                        r_m_complete, n_m_complete;

    logic                        in_xfer;
    logic [1:0]                  in_op;
    logic [rbt_pkg::WORD_W-1:0]  in_word;
    logic [rbt_pkg::IDX_W-1:0]   in_idx;
    logic [31:0]                 leaves;
    logic [NW-1:0]               target;
    logic                        mod_start;
    logic                        mod_done;
    logic [DW-1:0]               mod_rem;
    logic [DW-1:0]               divisor;
    logic [AW-1:0]               two_n;
    logic                        ram_we;
    logic [AW-1:0]               ram_addr;
    logic [AW-1:0]               ram_wdata;
    logic [AW-1:0]               ram_rdata;

    assign in_op   = s_axis_tuser;
    assign in_word = s_axis_tdata[30:0];
    assign in_idx  = s_axis_tdata[39:31];
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // N = clamp(leaf_count, 1, MAX_LEAVES) - 1
    always_comb begin
        if (r_leaf == '0) begin
            leaves = 32'd1;
        end else if ({23'd0, r_leaf} > 32'(MAX_LEAVES)) begin
            leaves = 32'(MAX_LEAVES);
        end else begin
            leaves = {23'd0, r_leaf};
        end
        target = NW'(leaves - 32'd1);
    end

    assign divisor   = {r_n, 2'b10};
    assign two_n     = AW'({r_n, 1'b0});
    assign mod_start = in_xfer && (in_op == rbt_pkg::OP_ADVANCE) && r_started
                       && (r_n < target);

    rbt_mod #(
        .DIV_W (DW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (in_word),
        .i_divisor  (divisor),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // link RAM port: clear entry 0 on start, read k or index, then three inserts with n already advanced
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_k;
        ram_wdata = two_n;
        case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_addr  = '0;
                ram_wdata = '0;
            end
            S_RD: begin
                ram_addr = (r_op == rbt_pkg::OP_READ) ? AW'(r_idx) : r_k;
            end
            S_WR1: begin
                ram_we    = 1'b1;
                ram_addr  = two_n - AW'(r_b);
                ram_wdata = two_n;
            end
            S_WR2: begin
                ram_we    = 1'b1;
                ram_addr  = two_n - AW'(1) + AW'(r_b);
                ram_wdata = r_old;
            end
            S_WR3: begin
                ram_we    = 1'b1;
                ram_addr  = r_k;
                ram_wdata = two_n - AW'(1);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    rbt_ram #(
        .WIDTH (AW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_idx        = r_idx;
        n_n          = r_n;
        n_started    = r_started;
        n_status     = r_status;
        n_k          = r_k;
        n_b          = r_b;
        n_old        = r_old;
        n_link       = r_link;
        n_m_valid    = r_m_valid;
        n_m_status   = r_m_status;
        n_m_link     = r_m_link;
        n_m_steps    = r_m_steps;
        n_m_complete = r_m_complete;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_op     = in_op;
                    n_idx    = in_idx;
                    n_status = rbt_pkg::ST_OK;
                    n_link   = '0;
                    n_state  = S_OUT;
                    case (in_op)
                        rbt_pkg::OP_START: begin
                            n_n       = '0;
                            n_started = 1'b1;
                            n_state   = S_INIT;
                        end
                        rbt_pkg::OP_ADVANCE: begin
                            if (!r_started) begin
                                n_status = rbt_pkg::ST_NOSTART;
                            end else if (r_n >= target) begin
                                n_status = rbt_pkg::ST_COMPLETE;
                            end else begin
                                n_state = S_DIV;
                            end
                        end
                        rbt_pkg::OP_READ: begin
                            if (!r_started) begin
                                n_status = rbt_pkg::ST_NOSTART;
                            end else if (CW'(in_idx) > CW'({r_n, 1'b0})
                                         || CW'(in_idx) >= CW'(DEPTH)) begin
                                n_status = rbt_pkg::ST_RANGE;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_INIT: begin
                n_state = S_OUT;
            end
            S_DIV: begin
                if (mod_done) begin
                    n_k     = AW'(mod_rem >> 1);
                    n_b     = mod_rem[0];
                    n_n     = r_n + 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CAP;
            end
            S_CAP: begin
                if (r_op == rbt_pkg::OP_READ) begin
                    n_link  = ram_rdata;
                    n_state = S_OUT;
                end else begin
                    n_old   = ram_rdata;
                    n_state = S_WR1;
                end
            end
            S_WR1: begin
                n_state = S_WR2;
            end
            S_WR2: begin
                n_state = S_WR3;
            end
            S_WR3: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid    = 1'b1;
                    n_m_status   = r_status;
                    n_m_link     = rbt_pkg::IDX_W'(r_link);
                    n_m_steps    = rbt_pkg::STEPS_W'(r_n);
                    n_m_complete = (r_n >= target);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_n       <= '0;
            r_started <= 1'b0;
            r_m_valid <= 1'b0;
            r_leaf    <= rbt_pkg::LEAF_W'(1);
        end else begin
            r_state   <= n_state;
            r_n       <= n_n;
            r_started <= n_started;
            r_m_valid <= n_m_valid;
            if (i_cfg_valid) begin
                r_leaf <= i_cfg_data;
            end
        end
        r_op         <= n_op;
        r_idx        <= n_idx;
        r_status     <= n_status;
        r_k          <= n_k;
        r_b          <= n_b;
        r_old        <= n_old;
        r_link       <= n_link;
        r_m_status   <= n_m_status;
        r_m_link     <= n_m_link;
        r_m_steps    <= n_m_steps;
        r_m_complete <= n_m_complete;
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = {6'd0, r_m_complete, r_m_steps, r_m_link};

`ifndef ASSERT_OFF
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> (r_state == S_DIV))
        else $error("modulo done outside divide state");

    a_rem_lt_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> (mod_rem < divisor))
        else $error("remainder not below divisor");

    a_step_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && mod_done) |=> (r_n == $past(r_n) + 1'b1))
        else $error("step count did not advance by one");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_started |-> (r_n == '0))
        else $error("steps nonzero before start");
`endif

endmodule
